// File: sv/omss_pkg.sv
// shared constants and status codes for the omega statistic stream unit
package omss_pkg;

  localparam int          FRAC_BITS_DEF = 16;
  localparam int          EPS_W         = 16;
  localparam logic [15:0] EPS_RESET     = 16'd655;

  localparam int OMEGA_W = 48;
  localparam int SUM_W   = 64;

  localparam logic [OMEGA_W-1:0] OMEGA_HI = {1'b0, {(OMEGA_W-1){1'b1}}};
  localparam logic [OMEGA_W-1:0] OMEGA_LO = {1'b1, {(OMEGA_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]   SUM_HI   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]   SUM_LO   = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

endpackage

// File: sv/omss_if.sv
// item channels of the omega statistic stream unit
interface omss_in_if;
  import omss_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  snps_left;
  logic [7:0]  snps_right;
  logic [31:0] ld_left_sum;
  logic [31:0] ld_right_sum;
  logic [32:0] ld_total_sum;
  logic        batch_last;

  modport source(output valid, snps_left, snps_right, ld_left_sum, ld_right_sum,
                 ld_total_sum, batch_last, input ready);
  modport sink(input valid, snps_left, snps_right, ld_left_sum, ld_right_sum,
               ld_total_sum, batch_last, output ready);
endinterface

interface omss_out_if;
  import omss_pkg::*;

  logic               valid;
  logic               ready;
  logic [OMEGA_W-1:0] omega;
  logic [1:0]         status;
  logic [OMEGA_W-1:0] batch_max;
  logic [OMEGA_W-1:0] batch_min;
  logic [SUM_W-1:0]   batch_sum;
  logic               batch_done;

  modport source(output valid, omega, status, batch_max, batch_min, batch_sum,
                 batch_done, input ready);
  modport sink(input valid, omega, status, batch_max, batch_min, batch_sum,
               batch_done, output ready);
endinterface

// File: sv/omega_statistic_stream_unit.sv
// omega statistic over a shared multiplier and a bit-serial divider
//
//  channel   dir   handshake      payload
//  sample    in    valid/ready    snps_left, snps_right, ld_*_sum, batch_last
//  result    out   valid/ready    omega, status, batch_max/min/sum, batch_done
//  cfg       in    cfg_we         cfg_wdata -> epsilon
//
// one item at a time: six multiply steps, then 49+FRAC_BITS restoring divide steps
// at one quotient bit a cycle, then saturate and statistics steps
// the zero divisor path skips the last multiply step, the divider and saturation
// reset (rst, synchronous) restores epsilon and clears the batch statistics
// a finished result sits in the output register; the next item is taken meanwhile
// and waits only at its own output step while the result side stalls
module omega_statistic_stream_unit #(
  parameter int FRAC_BITS = omss_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [omss_pkg::EPS_W-1:0] cfg_wdata,
  omss_in_if.sink                   sample,
  omss_out_if.source                result
);
  import omss_pkg::*;

  // operand a covers s, e and |d|; d needs one more bit for its sign
  localparam int AW  = ((FRAC_BITS + 16 > 33) ? FRAC_BITS + 16 : 33) + 1;
  localparam int DSW = AW + 1;
  localparam int PW  = AW + 16;
  localparam int NW  = 49 + FRAC_BITS;
  localparam int CW  = $clog2(NW);

  typedef enum logic [3:0] {
    IDLE, MUL_PM, MUL_PN, MUL_Q, MUL_EQ, MUL_SQ, MUL_PD, DIV, SAT, OUT
  } state_t;

  state_t state;

  logic [EPS_W-1:0] epsilon;
  logic [FRAC_BITS-1:0] eps_f;

  logic [7:0]  m, n;
  logic [32:0] s, csum;
  logic        last;

  logic [15:0]    p, q;
  logic [DSW-1:0] d;
  logic [AW-1:0]  dmag;
  logic           neg;

  logic [NW-1:0] dvd;
  logic [PW-1:0] divisor;
  logic [PW-1:0] rem;
  logic [47:0]   quo;
  logic          big;
  logic [CW-1:0] cnt;

  logic [OMEGA_W-1:0] omega_r;
  logic [1:0]         status_r;
  logic               upd;

  logic [OMEGA_W-1:0] max_so_far, min_so_far;
  logic [SUM_W-1:0]   sum_so_far;

  logic               out_valid;
  logic [OMEGA_W-1:0] out_omega, out_max, out_min;
  logic [1:0]         out_status;
  logic [SUM_W-1:0]   out_sum;
  logic               out_done;

  logic [AW-1:0] mul_a;
  logic [15:0]   mul_b;
  logic [PW-1:0] prod;

  logic [PW:0]   rem_sh, rem_diff;
  logic [OMEGA_W-1:0] max_next, min_next;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_next;

  if (FRAC_BITS >= 16) begin : g_eps_up
    assign eps_f = FRAC_BITS'(epsilon) << (FRAC_BITS - 16);
  end else begin : g_eps_dn
    assign eps_f = FRAC_BITS'(epsilon >> (16 - FRAC_BITS));
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      MUL_PM: begin
        mul_a = AW'(m);
        mul_b = (m == 8'd0) ? 16'd0 : 16'(m - 8'd1);
      end
      MUL_PN: begin
        mul_a = AW'(n);
        mul_b = (n == 8'd0) ? 16'd0 : 16'(n - 8'd1);
      end
      MUL_Q: begin
        mul_a = AW'(m);
        mul_b = 16'(n);
      end
      MUL_EQ: begin
        mul_a = AW'(eps_f);
        mul_b = q;
      end
      MUL_SQ: begin
        mul_a = AW'(s);
        mul_b = q;
      end
      MUL_PD: begin
        mul_a = dmag;
        mul_b = p;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // shared subtractor of the restoring divider
  assign rem_sh   = {rem, dvd[NW-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};

  // batch statistics with this item folded in
  always_comb begin
    max_next = max_so_far;
    min_next = min_so_far;
    sum_next = sum_so_far;
    sum_ext  = {sum_so_far[SUM_W-1], sum_so_far} +
               (SUM_W + 1)'($signed(omega_r));
    if (upd) begin
      if ($signed(omega_r) > $signed(max_so_far)) max_next = omega_r;
      if ($signed(omega_r) < $signed(min_so_far)) min_next = omega_r;
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
        sum_next = sum_ext[SUM_W] ? SUM_LO : SUM_HI;
      end else begin
        sum_next = sum_ext[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      epsilon    <= EPS_RESET;
      max_so_far <= '0;
      min_so_far <= OMEGA_HI;
      sum_so_far <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) epsilon <= cfg_wdata;
      if (out_valid && result.ready && state != OUT) out_valid <= 1'b0;

      unique case (state)
        IDLE: begin
          if (sample.valid) begin
            m     <= sample.snps_left;
            n     <= sample.snps_right;
            s     <= 33'(sample.ld_left_sum) + 33'(sample.ld_right_sum);
            csum  <= sample.ld_total_sum;
            last  <= sample.batch_last;
            state <= MUL_PM;
          end
        end
        MUL_PM: begin
          p     <= prod[16:1];
          state <= MUL_PN;
        end
        MUL_PN: begin
          p     <= p + prod[16:1];
          state <= MUL_Q;
        end
        MUL_Q: begin
          q     <= prod[15:0];
          state <= MUL_EQ;
        end
        MUL_EQ: begin
          d     <= DSW'(csum) - DSW'(s) + {1'b0, prod[AW-1:0]};
          state <= MUL_SQ;
        end
        MUL_SQ: begin
          dvd  <= NW'(prod[48:0]) << FRAC_BITS;
          neg  <= d[DSW-1];
          dmag <= d[DSW-1] ? AW'(-d) : AW'(d);
          if (p == 16'd0 || q == 16'd0 || d == '0) begin
            omega_r  <= '0;
            status_r <= STAT_ZERO;
            upd      <= 1'b0;
            state    <= OUT;
          end else begin
            state <= MUL_PD;
          end
        end
        MUL_PD: begin
          divisor <= prod;
          rem     <= '0;
          quo     <= '0;
          big     <= 1'b0;
          cnt     <= CW'(NW - 1);
          state   <= DIV;
        end
        DIV: begin
          dvd <= dvd << 1;
          big <= big | quo[47];
          if (!rem_diff[PW]) begin
            rem <= rem_diff[PW-1:0];
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem <= rem_sh[PW-1:0];
            quo <= {quo[46:0], 1'b0};
          end
          cnt <= cnt - CW'(1);
          if (cnt == '0) state <= SAT;
        end
        SAT: begin
          upd <= 1'b1;
          if (!neg) begin
            if (big || quo[47]) begin
              omega_r  <= OMEGA_HI;
              status_r <= STAT_SAT;
            end else begin
              omega_r  <= quo;
              status_r <= STAT_OK;
            end
          end else begin
            // magnitude 2^47 still fits as the most negative value
            if (big || (quo[47] && (|quo[46:0]))) begin
              omega_r  <= OMEGA_LO;
              status_r <= STAT_SAT;
            end else begin
              omega_r  <= -quo;
              status_r <= STAT_OK;
            end
          end
          state <= OUT;
        end
        OUT: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_omega  <= omega_r;
            out_status <= status_r;
            out_max    <= max_next;
            out_min    <= min_next;
            out_sum    <= sum_next;
            out_done   <= last;
            if (last) begin
              max_so_far <= '0;
              min_so_far <= OMEGA_HI;
              sum_so_far <= '0;
            end else begin
              max_so_far <= max_next;
              min_so_far <= min_next;
              sum_so_far <= sum_next;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign sample.ready      = (state == IDLE);
  assign result.valid      = out_valid;
  assign result.omega      = out_omega;
  assign result.status     = out_status;
  assign result.batch_max  = out_max;
  assign result.batch_min  = out_min;
  assign result.batch_sum  = out_sum;
  assign result.batch_done = out_done;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("took a second item while one is in work");

  a_zero_omega: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STAT_ZERO) |-> result.omega == '0)
    else $error("zero divisor result with nonzero omega");

  a_sat_rails: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STAT_SAT) |->
      (result.omega == OMEGA_HI || result.omega == OMEGA_LO))
    else $error("saturated result off the rails");

  a_max_floor: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !result.batch_max[OMEGA_W-1])
    else $error("batch maximum below zero");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.status == STAT_OK || result.status == STAT_ZERO ||
                      result.status == STAT_SAT))
    else $error("undefined status code");

endmodule

// File: tb/omega_statistic_stream_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the omega statistic stream unit
module omega_statistic_stream_unit_tb;
  import omss_pkg::*;

  localparam int FB         = FRAC_BITS_DEF;
  localparam int CYCLE_CAP  = 2_000_000;
  localparam int RAND_ITEMS = 230;  // per epsilon setting

  typedef struct packed {
    logic [7:0]  snps_left;
    logic [7:0]  snps_right;
    logic [31:0] ld_left_sum;
    logic [31:0] ld_right_sum;
    logic [32:0] ld_total_sum;
    logic        batch_last;
  } window_t;

  typedef struct packed {
    logic [OMEGA_W-1:0] omega;
    logic [1:0]         status;
    logic [OMEGA_W-1:0] batch_max;
    logic [OMEGA_W-1:0] batch_min;
    logic [SUM_W-1:0]   batch_sum;
    logic               batch_done;
  } omega_res_t;

  typedef enum logic [1:0] {ROW_EPS, ROW_PREDICT, ROW_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [EPS_W-1:0] eps;
    window_t          item;
    omega_res_t       want;
  } plan_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [EPS_W-1:0] cfg_wdata;

  omss_in_if  in_ch ();
  omss_out_if out_ch ();

  omega_statistic_stream_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .sample   (in_ch),
    .result   (out_ch)
  );

  // predictor copy of the register and the batch statistics
  logic [EPS_W-1:0]          eps_q;
  logic signed [OMEGA_W-1:0] run_max;
  logic signed [OMEGA_W-1:0] run_min;
  logic signed [SUM_W-1:0]   run_sum;

  omega_res_t omega_due[$];
  plan_row_t  plan[$];

  int     fails        = 0;
  int     results_seen = 0;
  int     items_sent   = 0;
  int     n_settings   = 0;
  int     n_zero       = 0;
  int     n_sat        = 0;
  bit     calm         = 1'b0;
  longint cycles       = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void clear_batch();
    run_max = '0;
    run_min = $signed(OMEGA_HI);
    run_sum = '0;
  endfunction

  function automatic logic [63:0] eps_scaled();
    return (FB >= 16) ? (64'(eps_q) << (FB - 16)) : (64'(eps_q) >> (16 - FB));
  endfunction

  function automatic omega_res_t omega_of_window(window_t w);
    logic [63:0]               m, n, pairs, mn, dmag;
    longint                    den;
    logic [127:0]              quot;
    logic signed [OMEGA_W-1:0] om;
    logic signed [SUM_W:0]     acc;
    omega_res_t                r;
    m     = 64'(w.snps_left);
    n     = 64'(w.snps_right);
    pairs = (m == 0 ? 64'd0 : m * (m - 1) / 2) + (n == 0 ? 64'd0 : n * (n - 1) / 2);
    mn    = m * n;
    den   = longint'(w.ld_total_sum) - longint'(w.ld_left_sum) - longint'(w.ld_right_sum)
          + longint'(eps_scaled() * mn);
    r            = '0;
    r.status     = STAT_OK;
    r.batch_done = w.batch_last;
    if (pairs == 0 || mn == 0 || den == 0) begin
      r.status = STAT_ZERO;
    end else begin
      dmag = (den < 0) ? 64'(-den) : 64'(den);
      quot = ((128'(64'(w.ld_left_sum) + 64'(w.ld_right_sum)) * 128'(mn)) << FB)
             / (128'(pairs) * 128'(dmag));
      if (den > 0) begin
        if (quot > 128'(OMEGA_HI)) begin
          om       = $signed(OMEGA_HI);
          r.status = STAT_SAT;
        end else begin
          om = quot[OMEGA_W-1:0];
        end
      end else begin
        // a negative magnitude may reach one step further than a positive one
        if (quot > 128'(OMEGA_HI) + 1) begin
          om       = $signed(OMEGA_LO);
          r.status = STAT_SAT;
        end else begin
          om = -quot[OMEGA_W-1:0];
        end
      end
      if (om > run_max) run_max = om;
      if (om < run_min) run_min = om;
      acc = run_sum + om;
      if (acc > $signed({1'b0, SUM_HI})) run_sum = $signed(SUM_HI);
      else if (acc < $signed({1'b1, SUM_LO})) run_sum = $signed(SUM_LO);
      else run_sum = acc[SUM_W-1:0];
      r.omega = om;
    end
    r.batch_max = run_max;
    r.batch_min = run_min;
    r.batch_sum = run_sum;
    if (w.batch_last) clear_batch();
    return r;
  endfunction

  function automatic window_t window(logic [7:0] m, logic [7:0] n, logic [31:0] l,
                                     logic [31:0] r, logic [32:0] c, logic last);
    window_t w;
    w.snps_left    = m;
    w.snps_right   = n;
    w.ld_left_sum  = l;
    w.ld_right_sum = r;
    w.ld_total_sum = c;
    w.batch_last   = last;
    return w;
  endfunction

  function automatic omega_res_t outcome(logic [OMEGA_W-1:0] om, logic [1:0] st,
                                         logic [OMEGA_W-1:0] mx, logic [OMEGA_W-1:0] mi,
                                         logic [SUM_W-1:0] sm, logic done);
    omega_res_t r;
    r.omega      = om;
    r.status     = st;
    r.batch_max  = mx;
    r.batch_min  = mi;
    r.batch_sum  = sm;
    r.batch_done = done;
    return r;
  endfunction

  task automatic add_row(row_kind_e kind, logic [EPS_W-1:0] eps, window_t w, omega_res_t want);
    plan_row_t row;
    row.kind = kind;
    row.eps  = eps;
    row.item = w;
    row.want = want;
    plan.push_back(row);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 16);
    return $urandom_range(20, 160);
  endfunction

  function automatic window_t random_window();
    window_t     w;
    int          pick;
    logic [32:0] lr;
    logic [63:0] ecq;
    logic [31:0] r0;
    pick           = $urandom_range(0, 99);
    w.batch_last   = ($urandom_range(0, 15) == 0);
    w.snps_left    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255))
                                                 : 8'($urandom_range(2, 40));
    w.snps_right   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255))
                                                 : 8'($urandom_range(2, 40));
    w.ld_left_sum  = $urandom >> $urandom_range(0, 31);
    w.ld_right_sum = $urandom >> $urandom_range(0, 31);
    lr             = 33'(w.ld_left_sum) + 33'(w.ld_right_sum);
    // cross-window linkage on top of both windows
    w.ld_total_sum = lr + (33'({$urandom, $urandom}) >> $urandom_range(0, 32));
    if (pick < 55) begin
      w.batch_last = w.batch_last;
    end else if (pick < 70) begin
      // total below the window sums, negative distance term
      w.ld_total_sum = lr - (33'({$urandom, $urandom}) >> $urandom_range(0, 32));
    end else if (pick < 80) begin
      w.snps_left    = 8'($urandom);
      w.snps_right   = 8'($urandom);
      w.ld_left_sum  = $urandom;
      w.ld_right_sum = $urandom;
      w.ld_total_sum = 33'({$urandom, $urandom});
    end else if (pick < 88) begin
      case ($urandom_range(0, 3))
        0: w.snps_left = '0;
        1: w.snps_right = '0;
        2: begin
          w.snps_left  = 8'd1;
          w.snps_right = 8'd1;
        end
        default: begin
          w.snps_left  = 8'($urandom_range(0, 1));
          w.snps_right = 8'($urandom_range(0, 1));
        end
      endcase
    end else if (pick < 94) begin
      // epsilon term cancels the distance term exactly
      ecq            = eps_scaled() * 64'(w.snps_left) * 64'(w.snps_right);
      r0             = $urandom_range(0, 32'hFFFF_FFFF - 32'(ecq));
      w.ld_right_sum = 32'(ecq) + r0;
      w.ld_total_sum = 33'(w.ld_left_sum) + 33'(r0);
    end else begin
      // large window sums over a tiny denominator
      w.snps_left    = 8'($urandom_range(2, 6));
      w.snps_right   = 8'($urandom_range(1, 6));
      w.ld_left_sum  = $urandom | 32'hC000_0000;
      w.ld_right_sum = $urandom | 32'hC000_0000;
      w.ld_total_sum = 33'(w.ld_left_sum) + 33'(w.ld_right_sum)
                     + 33'($urandom_range(0, 4)) - 33'd2;
    end
    return w;
  endfunction

  task automatic offer(window_t w, bit known, omega_res_t want, int gap);
    omega_res_t r;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.snps_left    <= w.snps_left;
    in_ch.snps_right   <= w.snps_right;
    in_ch.ld_left_sum  <= w.ld_left_sum;
    in_ch.ld_right_sum <= w.ld_right_sum;
    in_ch.ld_total_sum <= w.ld_total_sum;
    in_ch.batch_last   <= w.batch_last;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    r = omega_of_window(w);
    if (known) r = want;
    if (r.status == STAT_ZERO) n_zero++;
    if (r.status == STAT_SAT) n_sat++;
    omega_due.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  // every item yields a result, so an empty queue means the unit is idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (omega_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_epsilon(logic [EPS_W-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    eps_q = v;
    n_settings++;
  endtask

  function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    omega_res_t want;
    omega_res_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.omega      = out_ch.omega;
      got.status     = out_ch.status;
      got.batch_max  = out_ch.batch_max;
      got.batch_min  = out_ch.batch_min;
      got.batch_sum  = out_ch.batch_sum;
      got.batch_done = out_ch.batch_done;
      if (omega_due.size() == 0) begin
        $error("result with no item outstanding: omega %h", got.omega);
        fails++;
      end else begin
        want = omega_due.pop_front();
        field_check("omega", want.omega, got.omega);
        field_check("status", want.status, got.status);
        field_check("batch_max", want.batch_max, got.batch_max);
        field_check("batch_min", want.batch_min, got.batch_min);
        field_check("batch_sum", want.batch_sum, got.batch_sum);
        field_check("batch_done", want.batch_done, got.batch_done);
      end
      results_seen++;
    end
  end

  initial begin : result_pacer
    int on_len;
    int off_len;
    bit held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      on_len = $urandom_range(1, 24);
      out_ch.ready <= 1'b1;
      repeat (on_len) @(negedge clk);
      off_len = calm ? 0 : idle_len();
      // one long hold-off so the unit backs up into its input
      if (!held && results_seen >= 300) begin
        off_len = 900;
        held    = 1'b1;
      end
      if (off_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (off_len) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $error("timed out with %0d results outstanding", omega_due.size());
      $display("omega_statistic_stream_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t        row;
    logic [EPS_W-1:0] e;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.snps_left    = '0;
    in_ch.snps_right   = '0;
    in_ch.ld_left_sum  = '0;
    in_ch.ld_right_sum = '0;
    in_ch.ld_total_sum = '0;
    in_ch.batch_last   = 1'b0;
    eps_q              = EPS_RESET;
    clear_batch();

    // zero divisor in each form, statistics still at their reset values
    add_row(ROW_KNOWN, '0, window(0, 0, '0, '0, '0, 0),
            outcome('0, STAT_ZERO, '0, OMEGA_HI, '0, 0));
    add_row(ROW_KNOWN, '0, window(1, 1, '1, '1, '1, 0),
            outcome('0, STAT_ZERO, '0, OMEGA_HI, '0, 0));
    add_row(ROW_KNOWN, '0, window(255, 0, '1, '0, '1, 0),
            outcome('0, STAT_ZERO, '0, OMEGA_HI, '0, 0));
    add_row(ROW_KNOWN, '0, window(0, 255, '0, '1, '1, 1),
            outcome('0, STAT_ZERO, '0, OMEGA_HI, '0, 1));
    add_row(ROW_EPS, 16'd0, '0, '0);
    add_row(ROW_KNOWN, '0, window(2, 1, '0, '0, '0, 0),
            outcome('0, STAT_ZERO, '0, OMEGA_HI, '0, 0));
    // distance of plus and minus one: saturation both ways, sum lands on -1
    add_row(ROW_KNOWN, '0, window(2, 1, '1, '1, 33'h1_FFFF_FFFF, 0),
            outcome(OMEGA_HI, STAT_SAT, OMEGA_HI, OMEGA_HI, 64'(OMEGA_HI), 0));
    add_row(ROW_KNOWN, '0, window(2, 1, '1, '1, 33'h1_FFFF_FFFD, 1),
            outcome(OMEGA_LO, STAT_SAT, OMEGA_HI, OMEGA_LO, '1, 1));
    add_row(ROW_PREDICT, '0, window(255, 255, '1, '1, 33'h1_FFFF_FFFF, 0), '0);
    add_row(ROW_PREDICT, '0, window(3, 4, 32'h0001_0000, 32'h0002_0000, '0, 0), '0);
    add_row(ROW_EPS, 16'hFFFF, '0, '0);
    add_row(ROW_PREDICT, '0, window(255, 255, '0, '0, '0, 0), '0);
    add_row(ROW_PREDICT, '0, window(1, 2, 32'd1, '0, '0, 0), '0);
    add_row(ROW_PREDICT, '0, window(3, 3, 32'h8000_0000, 32'h8000_0000, '0, 0), '0);
    add_row(ROW_PREDICT, '0, window(2, 1, 32'd131070, '0, '0, 1), '0);
    add_row(ROW_EPS, EPS_RESET, '0, '0);
    add_row(ROW_PREDICT, '0, window(10, 12, 32'h0005_0000, 32'h0007_0000, 33'h28_0000, 0),
            '0);
    add_row(ROW_PREDICT, '0, window(40, 35, 32'h0012_3456, 32'h0009_8765, 33'h40_0000, 0),
            '0);
    add_row(ROW_PREDICT, '0, window(255, 1, 32'hFFFF_0000, '0, 33'h1_0000_0000, 0), '0);
    add_row(ROW_PREDICT, '0, window(1, 255, '0, 32'h00FF_FFFF, 33'h100_0000, 0), '0);
    add_row(ROW_PREDICT, '0,
            window(128, 128, 32'h8000_0000, 32'h7FFF_FFFF, 33'h1_FFFF_FFFF, 0), '0);
    add_row(ROW_PREDICT, '0, window(7, 9, 32'h0000_FFFF, 32'h0001_0000, 33'h1_FFFF, 1), '0);

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_EPS) begin
        settle();
        write_epsilon(row.eps);
      end else begin
        offer(row.item, row.kind == ROW_KNOWN, row.want, idle_len());
      end
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: e = 16'd1;
        1: e = '0;
        2: e = 16'($urandom);
        3: e = '1;
        default: e = EPS_RESET;
      endcase
      settle();
      write_epsilon(e);
      calm = (p == 2);  // back-to-back items and an always-ready receiver
      for (int i = 0; i < RAND_ITEMS; i++) begin
        offer(random_window(), 1'b0, '0, calm ? 0 : idle_len());
      end
      calm = 1'b0;
    end

    settle();
    repeat (100) @(posedge clk);
    $display("%0d items over %0d epsilon settings, %0d results checked",
             items_sent, n_settings, results_seen);
    $display("%0d zero-divisor and %0d saturated results among them", n_zero, n_sat);
    if (fails == 0) begin
      $display("omega_statistic_stream_unit: match");
    end else begin
      $display("omega_statistic_stream_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: omega_statistic_stream_unit.f
sv/omss_pkg.sv
sv/omss_if.sv
sv/omega_statistic_stream_unit.sv
tb/omega_statistic_stream_unit_tb.sv
